// File: hdl/m3i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, latencies and limits for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int ENTRY_W  = 16;               // Q4.12 matrix entry
	localparam int RESULT_W = 32;               // Q16.16 inverse entry
	localparam int PROD_W   = 2 * ENTRY_W;      // entry by entry product
	localparam int ADJ_W    = PROD_W + 1;       // cofactor, signed
	localparam int MAG_W    = PROD_W;           // cofactor magnitude
	localparam int DPROD_W  = ENTRY_W + ADJ_W - 1;
	localparam int DET_W    = DPROD_W + 2;      // exact determinant, signed
	localparam int DMAG_W   = DET_W - 1;        // determinant magnitude
	localparam int DET_OUT_W = 48;              // reported determinant
	localparam int LO_W     = 4;                // cofactor bits below the first step
	localparam int DIV_STEPS = RESULT_W;        // one quotient bit per stage
	localparam int LANES    = 9;
	localparam int FRONT_LAT = 4;
	localparam int LANE_LAT = DIV_STEPS + 2;
	localparam int PIPE_LAT = FRONT_LAT + LANE_LAT;

	localparam logic [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
	localparam logic [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

	localparam logic signed [DET_W-1:0] DET_HI = {{(DET_W-DET_OUT_W+1){1'b0}},
		{(DET_OUT_W-1){1'b1}}};
	localparam logic signed [DET_W-1:0] DET_LO = {{(DET_W-DET_OUT_W+1){1'b1}},
		{(DET_OUT_W-1){1'b0}}};

endpackage

// File: hdl/m3i_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_front
// Cofactor and determinant pipeline: products, adjugate, det products, det.
// ----------------------------------------------------------------------------
module m3i_front (
	input  logic clk,
	input  logic en,
	input  logic signed [m3i_pkg::ENTRY_W-1:0] a [9],
	output logic [m3i_pkg::MAG_W-1:0] c_mag [9],
	output logic c_neg [9],
	output logic [m3i_pkg::DMAG_W-1:0] d_mag,
	output logic d_neg,
	output logic d_zero,
	output logic [m3i_pkg::DET_OUT_W-1:0] det_out
);

	// operand pairs per cofactor: adj = a[IA]*a[IB] - a[IC]*a[ID]
	localparam int IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int IC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int ID [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	logic signed [m3i_pkg::PROD_W-1:0]  pa_s1 [9];
	logic signed [m3i_pkg::PROD_W-1:0]  pb_s1 [9];
	logic signed [m3i_pkg::ENTRY_W-1:0] r1_s1 [3];
	logic signed [m3i_pkg::ENTRY_W-1:0] r1_s2 [3];
	logic signed [m3i_pkg::ADJ_W-1:0]   adj_s2 [9];
	logic signed [m3i_pkg::ADJ_W-1:0]   adj_s3 [9];
	logic signed [m3i_pkg::DPROD_W-1:0] dp_s3 [3];
	logic signed [m3i_pkg::DET_W-1:0]   det_c;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				pa_s1[k] <= m3i_pkg::PROD_W'(a[IA[k]]) * m3i_pkg::PROD_W'(a[IB[k]]);
				pb_s1[k] <= m3i_pkg::PROD_W'(a[IC[k]]) * m3i_pkg::PROD_W'(a[ID[k]]);
				adj_s2[k] <= m3i_pkg::ADJ_W'(pa_s1[k]) - m3i_pkg::ADJ_W'(pb_s1[k]);
				adj_s3[k] <= adj_s2[k];
			end
			for (int k = 0; k < 3; k++) begin
				r1_s1[k] <= a[k];
				r1_s2[k] <= r1_s1[k];
			end
			// first row times first column of the adjugate
			dp_s3[0] <= m3i_pkg::DPROD_W'(r1_s2[0]) * m3i_pkg::DPROD_W'(adj_s2[0]);
			dp_s3[1] <= m3i_pkg::DPROD_W'(r1_s2[1]) * m3i_pkg::DPROD_W'(adj_s2[3]);
			dp_s3[2] <= m3i_pkg::DPROD_W'(r1_s2[2]) * m3i_pkg::DPROD_W'(adj_s2[6]);
		end
	end

	assign det_c = m3i_pkg::DET_W'(dp_s3[0]) + m3i_pkg::DET_W'(dp_s3[1])
		+ m3i_pkg::DET_W'(dp_s3[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				c_neg[k] <= adj_s3[k][m3i_pkg::ADJ_W-1];
				c_mag[k] <= adj_s3[k][m3i_pkg::ADJ_W-1] ?
					m3i_pkg::MAG_W'(-adj_s3[k]) : m3i_pkg::MAG_W'(adj_s3[k]);
			end
			d_neg  <= det_c[m3i_pkg::DET_W-1];
			d_mag  <= det_c[m3i_pkg::DET_W-1] ?
				m3i_pkg::DMAG_W'(-det_c) : m3i_pkg::DMAG_W'(det_c);
			d_zero <= (det_c == '0);
			if (det_c > m3i_pkg::DET_HI)
				det_out <= m3i_pkg::DET_OUT_W'(m3i_pkg::DET_HI);
			else if (det_c < m3i_pkg::DET_LO)
				det_out <= m3i_pkg::DET_OUT_W'(m3i_pkg::DET_LO);
			else
				det_out <= det_c[m3i_pkg::DET_OUT_W-1:0];
		end
	end

endmodule

// File: hdl/m3i_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_lane
// One division lane: restoring divider, one quotient bit per stage, saturate.
// ----------------------------------------------------------------------------
module m3i_lane (
	input  logic clk,
	input  logic en,
	input  logic [m3i_pkg::MAG_W-1:0]  c_mag,
	input  logic c_neg,
	input  logic [m3i_pkg::DMAG_W-1:0] d_mag,
	input  logic d_neg,
	output logic [m3i_pkg::RESULT_W-1:0] q_out,
	output logic clip
);

	localparam int N = m3i_pkg::DIV_STEPS;
	localparam int RW = m3i_pkg::DMAG_W;

	logic [RW-1:0]               rem_s [N+1];
	logic [m3i_pkg::RESULT_W-1:0] quo_s [N+1];
	logic [m3i_pkg::LO_W-1:0]    lo_s  [N+1];
	logic [RW-1:0]               den_s [N+1];
	logic                        neg_s [N+1];
	logic                        ovf_s [N+1];
	logic [RW-1:0]               head_c;

	// quotient at or above 2^RESULT_W when |c| >> LO_W is not below d
	assign head_c = RW'(c_mag[m3i_pkg::MAG_W-1:m3i_pkg::LO_W]);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= head_c;
			quo_s[0] <= '0;
			lo_s[0]  <= c_mag[m3i_pkg::LO_W-1:0];
			den_s[0] <= d_mag;
			neg_s[0] <= c_neg ^ d_neg;
			ovf_s[0] <= (head_c >= d_mag);
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW:0] shf_c;
		logic        ge_c;
		logic [RW:0] dif_c;
		assign shf_c = {rem_s[k], lo_s[k][m3i_pkg::LO_W-1]};
		assign ge_c  = (shf_c >= {1'b0, den_s[k]});
		assign dif_c = shf_c - {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge_c ? dif_c[RW-1:0] : shf_c[RW-1:0];
				quo_s[k+1] <= {quo_s[k][m3i_pkg::RESULT_W-2:0], ge_c};
				lo_s[k+1]  <= {lo_s[k][m3i_pkg::LO_W-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	logic [m3i_pkg::RESULT_W-1:0] qv_c;
	logic sgn_c, over_c;

	assign qv_c  = quo_s[N];
	assign sgn_c = neg_s[N] && (ovf_s[N] || qv_c != '0);
	assign over_c = ovf_s[N] || (sgn_c ? (qv_c > m3i_pkg::RES_MIN) : qv_c[m3i_pkg::RESULT_W-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			clip <= over_c;
			if (sgn_c)
				q_out <= over_c ? m3i_pkg::RES_MIN : -qv_c;
			else
				q_out <= over_c ? m3i_pkg::RES_MAX : qv_c;
		end
	end

endmodule

// File: hdl/matrix3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 matrix inverse by the adjugate, Q4.12 in, Q16.16 out, exact determinant.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | a11 .. a33
//  out     | out_valid / out_ready | inv11 .. inv33, det_value, singular,
//          |                       | saturated
//
//  One beat enters every cycle unless out stalls; each beat passes the registered
//  cofactor and determinant math, then 32 restoring-divider stages (one
//  quotient bit each) in nine parallel lanes, plus lane setup and saturation.
//  A stall on out holds the whole pipeline; in_ready drops only then.
//  Reset clears the valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module matrix3_inverse (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] a11,
	input  logic signed [15:0] a12,
	input  logic signed [15:0] a13,
	input  logic signed [15:0] a21,
	input  logic signed [15:0] a22,
	input  logic signed [15:0] a23,
	input  logic signed [15:0] a31,
	input  logic signed [15:0] a32,
	input  logic signed [15:0] a33,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] inv11,
	output logic signed [31:0] inv12,
	output logic signed [31:0] inv13,
	output logic signed [31:0] inv21,
	output logic signed [31:0] inv22,
	output logic signed [31:0] inv23,
	output logic signed [31:0] inv31,
	output logic signed [31:0] inv32,
	output logic signed [31:0] inv33,
	output logic signed [47:0] det_value,
	output logic singular,
	output logic saturated
);

	localparam int LL = m3i_pkg::LANE_LAT;

	logic adv;
	logic [m3i_pkg::PIPE_LAT-1:0] vld_q;

	logic signed [m3i_pkg::ENTRY_W-1:0] ent [9];
	logic [m3i_pkg::MAG_W-1:0]  c_mag [9];
	logic                       c_neg [9];
	logic [m3i_pkg::DMAG_W-1:0] d_mag;
	logic                       d_neg, d_zero;
	logic [m3i_pkg::DET_OUT_W-1:0] det_f;
	logic [m3i_pkg::RESULT_W-1:0] q [9];
	logic [m3i_pkg::LANES-1:0]  clip;
	logic [m3i_pkg::RESULT_W-1:0] res [9];

	logic [m3i_pkg::DET_OUT_W-1:0] det_s [LL];
	logic                          sing_s [LL];

	// advance whenever the output slot is empty or being drained
	assign adv       = !vld_q[m3i_pkg::PIPE_LAT-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[m3i_pkg::PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[m3i_pkg::PIPE_LAT-2:0], in_valid};
		end
	end

	assign ent = '{a11, a12, a13, a21, a22, a23, a31, a32, a33};

	m3i_front u_front (
		.clk    (clk),
		.en     (adv),
		.a      (ent),
		.c_mag  (c_mag),
		.c_neg  (c_neg),
		.d_mag  (d_mag),
		.d_neg  (d_neg),
		.d_zero (d_zero),
		.det_out(det_f)
	);

	// nine lanes divide the nine cofactors by the shared determinant
	for (genvar k = 0; k < m3i_pkg::LANES; k++) begin : g_lane
		m3i_lane u_lane (
			.clk  (clk),
			.en   (adv),
			.c_mag(c_mag[k]),
			.c_neg(c_neg[k]),
			.d_mag(d_mag),
			.d_neg(d_neg),
			.q_out(q[k]),
			.clip (clip[k])
		);
	end

	// carry determinant and singular flag alongside the lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s[0]  <= det_f;
			sing_s[0] <= d_zero;
			for (int k = 1; k < LL; k++) begin
				det_s[k]  <= det_s[k-1];
				sing_s[k] <= sing_s[k-1];
			end
		end
	end

	// merge: drop lane results on a singular matrix, fold clip flags
	always_comb begin
		for (int k = 0; k < 9; k++)
			res[k] = sing_s[LL-1] ? '0 : q[k];
	end

	assign inv11 = res[0];
	assign inv12 = res[1];
	assign inv13 = res[2];
	assign inv21 = res[3];
	assign inv22 = res[4];
	assign inv23 = res[5];
	assign inv31 = res[6];
	assign inv32 = res[7];
	assign inv33 = res[8];
	assign det_value = det_s[LL-1];
	assign singular  = sing_s[LL-1];
	assign saturated = !sing_s[LL-1] && (|clip);

	a_sing_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !saturated && inv11 == '0 && inv33 == '0)
		else $error("singular beat carries nonzero data");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output slot");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted beat lost at pipeline entry");
	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> det_value == '0)
		else $error("singular flag with nonzero determinant");

endmodule
